// File: src/assert_macros.svh
// Assertion macros used by the top level of the cache tag store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property sampled on the rising clock edge, disabled while reset is low.
`define SALC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define SALC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/salc_pkg.sv
// Shared types, constants and register codes of the cache tag store.
package salc_pkg;

  // Default geometry of the tag store.
  localparam int SETS_DEF = 64;
  localparam int WAYS_DEF = 8;

  // Fixed field widths.
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 62;
  localparam int CNT_W      = 32;
  localparam int OUT_DATA_W = 104;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // Configuration register values.
  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] offset_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } sts_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_e;

endpackage

// File: src/set_assoc_cache_lru_lookup_unit.sv
// Top level of the set-associative cache tag store with true LRU replacement.
// An accepted request moves the controller to its lookup state, which sets the result valid register.
// A new request is not taken during the lookup of the last one, set by the read-modify-write of one set row.
// A new request waits while an undelivered result would still be held at its lookup.
// Reset: counters and control clear at once; a sweep then zeroes each of the SETS rows of the
// tag store, with s_axis_tready low throughout (configuration writes still taken).
`include "assert_macros.svh"

module set_assoc_cache_lru_lookup_unit #(
  parameter int SETS = salc_pkg::SETS_DEF,
  parameter int WAYS = salc_pkg::WAYS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [salc_pkg::ADDR_W-1:0]      s_axis_tdata,   // address[63:0]
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit[0], evicted[1], hits_total[33:2], misses_total[65:34],
  // evictions_total[97:66], zero fill[103:98]
  output logic [salc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]     paddr,
  input  logic [salc_pkg::PDATA_W-1:0]     pwdata,
  output logic [salc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import salc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= 3'd1;
      cfg_q.offset_bits <= 6'd1;
      cfg_q.ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SET_BITS:    cfg_q.set_bits    <= pwdata[2:0];
        REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[5:0];
        REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[3:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:    prdata = {29'b0, cfg_q.set_bits};
      REG_OFFSET_BITS: prdata = {26'b0, cfg_q.offset_bits};
      REG_WAYS_IN_USE: prdata = {28'b0, cfg_q.ways_in_use};
      default:         prdata = '0;
    endcase
  end

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  salc_dpath #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .addr_i     (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

  // A request is never taken while a pending result stays stalled.
  `SALC_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready, "request taken over a stalled result")

  // Every accepted request is followed by a valid result.
  `SALC_ASSERT(a_latency, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid, "result missing two cycles after request")

  // A hit never reports an eviction.
  `SALC_ASSERT_IMPL(a_hit_no_evict, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "hit and eviction both set")

  // The running hit count never goes down.
  `SALC_ASSERT(a_hits_mono, clk_i, rst_ni, m_axis_tdata[33:2] >= $past(m_axis_tdata[33:2]), "hit count decreased")

endmodule

// File: src/salc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/salc_ctrl.sv
// Controller state machine: clearing sweep, request handshake and result valid.
module salc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  input  salc_pkg::sts_t sts_i,
  output salc_pkg::cmd_t cmd_o
);
  import salc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   ready;

  // A request is taken only when the result register is free by the lookup cycle.
  assign ready = (state_q == S_IDLE) && (!out_valid_q || m_tready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid_i && ready) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      S_IDLE: begin
        cmd_o.capture = s_tvalid_i && ready;
      end
      S_LOOKUP: begin
        cmd_o.update = 1'b1;
        out_valid_d  = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign s_tready_o = ready;
  assign m_tvalid_o = out_valid_q;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/salc_dpath.sv
// Datapath: address split, set row read, way compare, LRU update and counters.
module salc_dpath #(
  parameter int SETS = salc_pkg::SETS_DEF,
  parameter int WAYS = salc_pkg::WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  salc_pkg::cfg_t                  cfg_i,
  input  salc_pkg::cmd_t                  cmd_i,
  output salc_pkg::sts_t                  sts_o,
  input  logic [salc_pkg::ADDR_W-1:0]     addr_i,
  output logic [salc_pkg::OUT_DATA_W-1:0] out_data_o
);
  import salc_pkg::*;

  localparam int SIDX_W = $clog2(SETS);
  localparam int MSB    = $clog2(SETS + 1) - 1;
  localparam logic [3:0] MSB_CAP = (MSB > 7) ? 4'd7 : 4'(MSB);
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W  = TAG_W + 1 + RANK_W;
  localparam int ROW_W  = WAYS * ENT_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // Request registers.
  logic [SIDX_W-1:0] set_d, set_q;
  logic [TAG_W-1:0]  tag_d, tag_q;
  logic [WAYS-1:0]   en_d, en_q;

  // Clearing sweep index.
  logic [SIDX_W-1:0] clr_idx_q;

  // RAM ports.
  logic              ram_we;
  logic [SIDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  row_rd;
  logic [ROW_W-1:0]  row_wr;

  // Lookup results.
  logic              hit, evict;
  logic [CNT_W-1:0]  hits_q, misses_q, evicts_q;
  logic              out_hit_q, out_evict_q;

  // Split the incoming address using the effective configuration.
  always_comb begin
    logic [2:0]        sb;
    logic [5:0]        ob;
    logic [6:0]        total;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] tag_full;
    logic [4:0]        nw;
    sb = (cfg_i.set_bits == 3'd0) ? 3'd1 : cfg_i.set_bits;
    if ({1'b0, sb} > MSB_CAP) begin
      sb = MSB_CAP[2:0];
    end
    ob       = (cfg_i.offset_bits == 6'd0) ? 6'd1 : cfg_i.offset_bits;
    total    = {1'b0, ob} + {4'b0, sb};
    blk      = addr_i >> ob;
    set_d    = blk[SIDX_W-1:0] & ~({SIDX_W{1'b1}} << sb);
    tag_full = total[6] ? '0 : (addr_i >> total[5:0]);
    tag_d    = tag_full[TAG_W-1:0];
    nw       = {1'b0, cfg_i.ways_in_use};
    if (nw == 5'd0) begin
      nw = 5'd1;
    end
    if (nw > 5'(WAYS)) begin
      nw = 5'(WAYS);
    end
    for (int j = 0; j < WAYS; j++) begin
      en_d[j] = 5'(j) < nw;
    end
  end

  // Capture the split request when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q <= set_d;
      tag_q <= tag_d;
      en_q  <= en_d;
    end
  end

  // Compare across ways, choose the touched way and build the new row.
  always_comb begin
    logic              v [WAYS];
    logic [RANK_W-1:0] r [WAYS];
    logic [TAG_W-1:0]  t [WAYS];
    logic [WAYS-1:0]   match, inv, ismax;
    logic [WIDX_W-1:0] hit_way, inv_way, max_way, victim;
    logic              was_valid;
    logic [RANK_W-1:0] old_rank;
    logic [ENT_W-1:0]  ent;
    for (int j = 0; j < WAYS; j++) begin
      v[j] = row_rd[j*ENT_W];
      r[j] = row_rd[j*ENT_W+1 +: RANK_W];
      t[j] = row_rd[j*ENT_W+1+RANK_W +: TAG_W];
    end
    for (int j = 0; j < WAYS; j++) begin
      match[j] = en_q[j] && v[j] && (t[j] == tag_q);
      inv[j]   = en_q[j] && !v[j];
      ismax[j] = en_q[j];
      for (int k = 0; k < WAYS; k++) begin
        if (en_q[k] && (r[k] > r[j])) begin
          ismax[j] = 1'b0;
        end
      end
    end
    // Lowest-index pick for each candidate set.
    hit_way = '0;
    inv_way = '0;
    max_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_way = WIDX_W'(j);
      end
      if (inv[j]) begin
        inv_way = WIDX_W'(j);
      end
      if (ismax[j]) begin
        max_way = WIDX_W'(j);
      end
    end
    hit   = |match;
    evict = !hit && !(|inv);
    if (hit) begin
      victim = hit_way;
    end else if (|inv) begin
      victim = inv_way;
    end else begin
      victim = max_way;
    end
    was_valid = v[victim];
    old_rank  = r[victim];
    // The touched way becomes most recent; younger valid ways age by one.
    row_wr = row_rd;
    for (int j = 0; j < WAYS; j++) begin
      ent = row_rd[j*ENT_W +: ENT_W];
      if (en_q[j]) begin
        if (WIDX_W'(j) == victim) begin
          ent = {tag_q, {RANK_W{1'b0}}, 1'b1};
        end else if (v[j] && (!was_valid || (r[j] < old_rank)) && (r[j] != RANK_MAX)) begin
          ent = {t[j], r[j] + RANK_W'(1), 1'b1};
        end
      end
      row_wr[j*ENT_W +: ENT_W] = ent;
    end
  end

  // Tag store write: zero rows during the sweep, updated row after a lookup.
  assign ram_we    = cmd_i.clear || cmd_i.update;
  assign ram_waddr = cmd_i.clear ? clr_idx_q : set_q;
  assign ram_wdata = cmd_i.clear ? '0 : row_wr;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (set_d),
    .rdata_o (row_rd)
  );

  // Clearing sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + SIDX_W'(1);
    end
  end

  assign sts_o.clear_last = (clr_idx_q == SIDX_W'(SETS - 1));

  // Saturating running counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.update) begin
      if (hit && (hits_q != CNT_MAX)) begin
        hits_q <= hits_q + CNT_W'(1);
      end
      if (!hit && (misses_q != CNT_MAX)) begin
        misses_q <= misses_q + CNT_W'(1);
      end
      if (evict && (evicts_q != CNT_MAX)) begin
        evicts_q <= evicts_q + CNT_W'(1);
      end
    end
  end

  // Result flags held until the next lookup.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_hit_q   <= hit;
      out_evict_q <= evict;
    end
  end

  assign out_data_o = {6'b0, evicts_q, misses_q, hits_q, out_evict_q, out_hit_q};

endmodule
